// ===== hw/rtl/stsf_pkg.sv =====
// Shared types and constants for the shaded triangle span fill core.
// Holds the operation codes, the slope selector and the controller/datapath
// command and status bundles. No dependencies.
package stsf_pkg;

  localparam int COORD_W = 12;
  localparam int COUNT_W = 17;
  localparam int ADDR_W  = 17;
  localparam int BYTE_W  = 8;
  localparam int SEL_W   = 3;
  localparam int EDGE_W  = 48;
  localparam int FRAC_W  = 16;
  localparam int QUOT_W  = 28;
  localparam int TBL_W   = 4;

  // span rounding biases in Q32.16 (0.4 and 0.6)
  localparam logic signed [EDGE_W-1:0] LEFT_BIAS  = 48'sd26214;
  localparam logic signed [EDGE_W-1:0] RIGHT_BIAS = 48'sd39322;

  typedef enum logic [1:0] {
    MODE_DRAW  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_LOAD  = 2'd3
  } stsf_mode_t;

  typedef enum logic [1:0] {
    SLOPE_LONG   = 2'd0,
    SLOPE_SHORT1 = 2'd1,
    SLOPE_SHORT2 = 2'd2
  } stsf_slope_t;

  typedef struct packed {
    logic        load;
    logic        sort;
    logic        div_start;
    stsf_slope_t div_sel;
    logic        row_init;
    logic        row_next;
    logic        span_calc;
    logic        base_calc;
    logic        reduce;
    logic        pix_rd;
    logic        pix_wr;
    logic        frame_wr;
    logic        shade_wr;
    logic        rd_capture;
    logic        out_load;
  } stsf_cmd_t;

  typedef struct packed {
    stsf_mode_t mode;
    logic       degenerate;
    logic       need_s1;
    logic       need_s2;
    logic       div_done;
    logic       row_end;
    logic       row_visible;
    logic       span_empty;
    logic       reduce_done;
    logic       pix_last;
  } stsf_status_t;

  // integer coordinate to Q32.16 edge value
  function automatic logic signed [EDGE_W-1:0] to_edge(input logic signed [COORD_W-1:0] v);
    return {{(EDGE_W-COORD_W-FRAC_W){v[COORD_W-1]}}, v, {FRAC_W{1'b0}}};
  endfunction

endpackage

// ===== hw/rtl/shaded_triangle_span_fill_core.sv =====
// Top level of the shaded triangle span fill core.
// Depends on stsf_pkg, stsf_ctrl, stsf_dp (which holds the stsf_ram instances).

// One item is taken at a time. A finished result waits in an output register
// while the next item is accepted, and an item only completes once the previous
// result has been taken. A draw that is not degenerate sorts its vertices, then
// computes its edge slopes by two or three serial 28-step divisions (the long
// edge and each short edge of non-zero height), then walks its rows: a row
// outside the visible band is only stepped, a visible row has its span computed
// and, if the span is not empty, its row base reduced once per frame wrap; each
// covered pixel is a read of the frame store, a lookup in the shade store and a
// write back through the single frame memory.
module shaded_triangle_span_fill_core
  import stsf_pkg::*;
#(
  parameter int ROW_PIXELS   = 512,
  parameter int VISIBLE_ROWS = 200,
  parameter int FRAME_OFFSET = 96,
  parameter int SHADE_TABLES = 8,
  parameter int FRAME_DEPTH  = 131072
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic signed [COORD_W-1:0] vert_a_x,
  input  logic signed [COORD_W-1:0] vert_a_y,
  input  logic signed [COORD_W-1:0] vert_b_x,
  input  logic signed [COORD_W-1:0] vert_b_y,
  input  logic signed [COORD_W-1:0] vert_c_x,
  input  logic signed [COORD_W-1:0] vert_c_y,
  input  logic [SEL_W-1:0]          shade_select,
  input  logic [ADDR_W-1:0]         address,
  input  logic [BYTE_W-1:0]         write_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [BYTE_W-1:0]         read_value,
  output logic [COUNT_W-1:0]        pixels_shaded
);

  stsf_cmd_t    cmd;
  stsf_status_t status;

  // sequencer
  stsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath with memories
  stsf_dp #(
    .ROW_PIXELS   (ROW_PIXELS),
    .VISIBLE_ROWS (VISIBLE_ROWS),
    .FRAME_OFFSET (FRAME_OFFSET),
    .SHADE_TABLES (SHADE_TABLES),
    .FRAME_DEPTH  (FRAME_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .vert_a_x      (vert_a_x),
    .vert_a_y      (vert_a_y),
    .vert_b_x      (vert_b_x),
    .vert_b_y      (vert_b_y),
    .vert_c_x      (vert_c_x),
    .vert_c_y      (vert_c_y),
    .shade_select  (shade_select),
    .address       (address),
    .write_value   (write_value),
    .read_value    (read_value),
    .pixels_shaded (pixels_shaded)
  );

endmodule

// ===== hw/rtl/stsf_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module stsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/stsf_ctrl.sv =====
// Controller state machine for the span fill core.
// Depends on stsf_pkg; drives the datapath by command, reads its status.
module stsf_ctrl
  import stsf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  stsf_status_t status,
  output stsf_cmd_t    cmd
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_DECODE = 18'b000000000000000010,
    S_SORT   = 18'b000000000000000100,
    S_DSTART = 18'b000000000000001000,
    S_DWAIT  = 18'b000000000000010000,
    S_RINIT  = 18'b000000000000100000,
    S_ROW    = 18'b000000000001000000,
    S_SPAN   = 18'b000000000010000000,
    S_SPCHK  = 18'b000000000100000000,
    S_RED    = 18'b000000001000000000,
    S_PRD    = 18'b000000010000000000,
    S_PSH    = 18'b000000100000000000,
    S_PWR    = 18'b000001000000000000,
    S_FWR    = 18'b000010000000000000,
    S_FRD    = 18'b000100000000000000,
    S_FRDW   = 18'b001000000000000000,
    S_SWR    = 18'b010000000000000000,
    S_DONE   = 18'b100000000000000000
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  stsf_slope_t div_idx, div_idx_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    div_idx_next = div_idx;
    cmd          = '0;
    cmd.div_sel  = div_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.mode)
          MODE_DRAW:  state_next = S_SORT;
          MODE_WRITE: state_next = S_FWR;
          MODE_READ:  state_next = S_FRD;
          MODE_LOAD:  state_next = S_SWR;
          default:    state_next = S_DONE;
        endcase
      end
      S_SORT: begin
        cmd.sort = 1'b1;
        if (status.degenerate) begin
          state_next = S_DONE;
        end else begin
          div_idx_next = SLOPE_LONG;
          state_next   = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          if (div_idx == SLOPE_LONG && status.need_s1) begin
            div_idx_next = SLOPE_SHORT1;
            state_next   = S_DSTART;
          end else if (div_idx != SLOPE_SHORT2 && status.need_s2) begin
            div_idx_next = SLOPE_SHORT2;
            state_next   = S_DSTART;
          end else begin
            state_next = S_RINIT;
          end
        end
      end
      S_RINIT: begin
        cmd.row_init = 1'b1;
        state_next   = S_ROW;
      end
      S_ROW: begin
        if (status.row_end) begin
          state_next = S_DONE;
        end else if (!status.row_visible) begin
          cmd.row_next = 1'b1;
        end else begin
          state_next = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.span_calc = 1'b1;
        state_next    = S_SPCHK;
      end
      S_SPCHK: begin
        if (status.span_empty) begin
          cmd.row_next = 1'b1;
          state_next   = S_ROW;
        end else begin
          cmd.base_calc = 1'b1;
          state_next    = S_RED;
        end
      end
      S_RED: begin
        if (status.reduce_done) begin
          state_next = S_PRD;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      S_PRD: begin
        cmd.pix_rd = 1'b1;
        state_next = S_PSH;
      end
      S_PSH: begin
        state_next = S_PWR;
      end
      S_PWR: begin
        cmd.pix_wr = 1'b1;
        if (status.pix_last) begin
          cmd.row_next = 1'b1;
          state_next   = S_ROW;
        end else begin
          state_next = S_PRD;
        end
      end
      S_FWR: begin
        cmd.frame_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_FRD: begin
        state_next = S_FRDW;
      end
      S_FRDW: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_SWR: begin
        cmd.shade_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_idx <= SLOPE_LONG;
    end else begin
      state   <= state_next;
      div_idx <= div_idx_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  // a new result only appears from the completion state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion state");

  // every pixel write follows a shade lookup cycle
  a_write_after_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == S_PWR) |-> $past(state == S_PSH))
    else $error("pixel write without shade lookup");

  // no new item while a draw is still dividing or walking rows
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW || state == S_DWAIT) |-> !in_ready)
    else $error("ready during draw");
`endif

endmodule

// ===== hw/rtl/stsf_dp.sv =====
// Datapath for the span fill core: operand registers, slope divider, edge
// walkers, span setup, frame and shade memories. Depends on stsf_pkg, stsf_ram.
module stsf_dp
  import stsf_pkg::*;
#(
  parameter int ROW_PIXELS   = 512,
  parameter int VISIBLE_ROWS = 200,
  parameter int FRAME_OFFSET = 96,
  parameter int SHADE_TABLES = 8,
  parameter int FRAME_DEPTH  = 131072
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stsf_cmd_t                 cmd,
  output stsf_status_t              status,
  input  logic [1:0]                mode,
  input  logic signed [COORD_W-1:0] vert_a_x,
  input  logic signed [COORD_W-1:0] vert_a_y,
  input  logic signed [COORD_W-1:0] vert_b_x,
  input  logic signed [COORD_W-1:0] vert_b_y,
  input  logic signed [COORD_W-1:0] vert_c_x,
  input  logic signed [COORD_W-1:0] vert_c_y,
  input  logic [SEL_W-1:0]          shade_select,
  input  logic [ADDR_W-1:0]         address,
  input  logic [BYTE_W-1:0]         write_value,
  output logic [BYTE_W-1:0]         read_value,
  output logic [COUNT_W-1:0]        pixels_shaded
);

  localparam int FAW = $clog2(FRAME_DEPTH);
  localparam int SAW = $clog2(SHADE_TABLES * 256);
  localparam int CW  = $clog2(ROW_PIXELS + 1);
  localparam int RW  = $clog2(VISIBLE_ROWS);
  localparam int BW  = $clog2(VISIBLE_ROWS * ROW_PIXELS + FRAME_OFFSET + FRAME_DEPTH);

  // latched item
  stsf_mode_t                mode_q;
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic [SEL_W-1:0]          sel_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [BYTE_W-1:0]         val_q;

  // sorted vertices
  logic [1:0]                vt, vb, vm;
  logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2;

  // slopes and edges
  logic signed [EDGE_W-1:0]  slong, s1, s2, ssh, lng, sht;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] y_inc;

  // divider
  logic [COORD_W-1:0]        d_rem;
  logic [QUOT_W-1:0]         d_num;
  logic [COORD_W-1:0]        d_den;
  logic                      d_neg;
  logic [4:0]                d_cnt;
  logic                      d_busy;
  logic                      d_done;
  stsf_slope_t               d_sel;
  logic [COORD_W:0]          d_trial;
  logic                      d_qbit;
  logic [COORD_W-1:0]        d_rem_next;
  logic [QUOT_W-1:0]         d_num_next;
  logic signed [EDGE_W-1:0]  d_quot;
  logic signed [EDGE_W-1:0]  d_slope;
  logic signed [COORD_W:0]   dx, dy, dxm;

  // span and pixel walk
  logic signed [EDGE_W-1:0]  lo, hi, lsum, rsum;
  logic signed [31:0]        lf, rf, lc, rc;
  logic [CW-1:0]             span_l, span_n, prem;
  logic                      span_empty;
  logic [BW-1:0]             pbase, amod;
  logic [COUNT_W-1:0]        count;
  logic [BYTE_W-1:0]         rd_q;
  logic [TBL_W-1:0]          tbl;

  // memories
  logic                      f_we;
  logic [FAW-1:0]            f_waddr, f_raddr;
  logic [BYTE_W-1:0]         f_wdata, f_q;
  logic [SAW-1:0]            s_waddr, s_raddr;
  logic [BYTE_W-1:0]         s_q;

  function automatic logic signed [COORD_W-1:0] pick(
    input logic [1:0] i,
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b,
    input logic signed [COORD_W-1:0] c
  );
    logic signed [COORD_W-1:0] r;
    case (i)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= stsf_mode_t'(mode);
      ax     <= vert_a_x;
      ay     <= vert_a_y;
      bx     <= vert_b_x;
      by     <= vert_b_y;
      cx     <= vert_c_x;
      cy     <= vert_c_y;
      sel_q  <= shade_select;
      addr_q <= address;
      val_q  <= write_value;
    end
  end

  // table select modulo table count
  always_comb begin
    tbl = TBL_W'(sel_q);
    for (int i = 0; i < 8; i++) begin
      if (int'(tbl) >= SHADE_TABLES) begin
        tbl = tbl - TBL_W'(SHADE_TABLES);
      end
    end
  end

  // frame address modulo depth (address is below twice the depth)
  always_comb begin
    amod = BW'(addr_q);
    if (amod >= BW'(FRAME_DEPTH)) begin
      amod = amod - BW'(FRAME_DEPTH);
    end
  end

  // vertex ordering, ties as top: later wins, bottom: later wins
  always_comb begin
    if (ay >= by) vt = (by >= cy) ? 2'd2 : 2'd1;
    else          vt = (ay < cy) ? 2'd0 : 2'd2;
    if (ay <= by) vb = (by <= cy) ? 2'd2 : 2'd1;
    else          vb = (ay > cy) ? 2'd0 : 2'd2;
    vm = 2'd3 - vt - vb;
  end

  always_ff @(posedge clk) begin
    if (cmd.sort) begin
      x0 <= pick(vt, ax, bx, cx);
      y0 <= pick(vt, ay, by, cy);
      x1 <= pick(vm, ax, bx, cx);
      y1 <= pick(vm, ay, by, cy);
      x2 <= pick(vb, ax, bx, cx);
      y2 <= pick(vb, ay, by, cy);
    end
  end

  // divider operands for the selected edge
  always_comb begin
    case (cmd.div_sel)
      SLOPE_SHORT1: begin
        dx = {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
        dy = {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
      end
      SLOPE_SHORT2: begin
        dx = {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
        dy = {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
      end
      default: begin
        dx = {x2[COORD_W-1], x2} - {x0[COORD_W-1], x0};
        dy = {y2[COORD_W-1], y2} - {y0[COORD_W-1], y0};
      end
    endcase
    dxm = dx[COORD_W] ? -dx : dx;
  end

  // one restoring step per cycle
  always_comb begin
    d_trial = {d_rem, d_num[QUOT_W-1]};
    d_qbit  = (d_trial >= {1'b0, d_den});
    d_rem_next = d_qbit ? COORD_W'(d_trial - {1'b0, d_den}) : COORD_W'(d_trial);
    d_num_next = {d_num[QUOT_W-2:0], d_qbit};
    d_quot  = EDGE_W'(d_num_next);
    d_slope = d_neg ? -d_quot : d_quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_busy <= 1'b0;
      d_done <= 1'b0;
    end else begin
      d_done <= 1'b0;
      if (cmd.div_start) begin
        d_busy <= 1'b1;
      end else if (d_busy && d_cnt == 5'd1) begin
        d_busy <= 1'b0;
        d_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      d_num <= {dxm[COORD_W-1:0], {FRAC_W{1'b0}}};
      d_den <= dy[COORD_W-1:0];
      d_neg <= dx[COORD_W];
      d_rem <= '0;
      d_cnt <= 5'(QUOT_W);
      d_sel <= cmd.div_sel;
    end else if (d_busy) begin
      d_num <= d_num_next;
      d_rem <= d_rem_next;
      d_cnt <= d_cnt - 5'd1;
      if (d_cnt == 5'd1) begin
        case (d_sel)
          SLOPE_SHORT1: s1    <= d_slope;
          SLOPE_SHORT2: s2    <= d_slope;
          default:      slong <= d_slope;
        endcase
      end
    end
  end

  // edge walk, short edge restarts at the middle vertex
  assign y_inc = y + COORD_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.row_init) begin
      y   <= y0;
      lng <= to_edge(x0);
      sht <= (y0 == y1) ? to_edge(x1) : to_edge(x0);
      ssh <= (y0 == y1) ? s2 : s1;
    end else if (cmd.row_next) begin
      y   <= y_inc;
      lng <= lng + slong;
      if (y_inc == y1) begin
        sht <= to_edge(x1);
        ssh <= s2;
      end else begin
        sht <= sht + ssh;
      end
    end
  end

  // span bounds for the current row
  always_comb begin
    lo   = (sht < lng) ? sht : lng;
    hi   = (sht < lng) ? lng : sht;
    lsum = lo + LEFT_BIAS;
    rsum = hi + RIGHT_BIAS;
    lf   = $signed(lsum[FRAC_W+31:FRAC_W]);
    rf   = $signed(rsum[FRAC_W+31:FRAC_W]);
    lc   = (lf < 0) ? 32'sd0 : lf;
    rc   = (rf > ROW_PIXELS) ? 32'(ROW_PIXELS) : rf;
  end

  always_ff @(posedge clk) begin
    if (cmd.span_calc) begin
      span_l     <= CW'(lc);
      span_n     <= CW'(rc - lc);
      span_empty <= (lc >= rc);
    end
  end

  // row base address, reduction and pixel stepping
  always_ff @(posedge clk) begin
    if (cmd.base_calc) begin
      pbase <= BW'(y[RW-1:0]) * BW'(ROW_PIXELS) + BW'(FRAME_OFFSET) + BW'(span_l);
      prem  <= span_n;
    end else if (cmd.reduce) begin
      if (pbase >= BW'(FRAME_DEPTH)) begin
        pbase <= pbase - BW'(FRAME_DEPTH);
      end
    end else if (cmd.pix_wr) begin
      prem  <= prem - CW'(1);
      pbase <= (pbase == BW'(FRAME_DEPTH - 1)) ? '0 : pbase + BW'(1);
    end
  end

  // count and read-back
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= '0;
      rd_q  <= '0;
    end else begin
      if (cmd.pix_wr) begin
        count <= count + COUNT_W'(1);
      end
      if (cmd.rd_capture) begin
        rd_q <= f_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value    <= rd_q;
      pixels_shaded <= count;
    end
  end

  // memory ports
  assign f_raddr = cmd.pix_rd ? FAW'(pbase) : FAW'(amod);
  assign f_we    = cmd.pix_wr | cmd.frame_wr;
  assign f_waddr = cmd.pix_wr ? FAW'(pbase) : FAW'(amod);
  assign f_wdata = cmd.pix_wr ? s_q : val_q;
  assign s_raddr = SAW'({tbl, f_q});
  assign s_waddr = SAW'({tbl, addr_q[BYTE_W-1:0]});

  stsf_ram #(.WIDTH(BYTE_W), .DEPTH(FRAME_DEPTH)) u_frame (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_q)
  );

  stsf_ram #(.WIDTH(BYTE_W), .DEPTH(SHADE_TABLES * 256)) u_shade (
    .clk   (clk),
    .we    (cmd.shade_wr),
    .waddr (s_waddr),
    .wdata (val_q),
    .raddr (s_raddr),
    .rdata (s_q)
  );

  // status
  always_comb begin
    status.mode        = mode_q;
    status.degenerate  = (ay == by) && (by == cy);
    status.need_s1     = (y1 > y0);
    status.need_s2     = (y2 > y1);
    status.div_done    = d_done;
    status.row_end     = (y == y2);
    status.row_visible = (y > 0) && (y < VISIBLE_ROWS);
    status.span_empty  = span_empty;
    status.reduce_done = (pbase < BW'(FRAME_DEPTH));
    status.pix_last    = (prem == CW'(1));
  end

`ifndef SYNTH
  // pixels are only touched on visible, non-empty rows
  a_pix_on_visible: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_wr |-> (status.row_visible && !span_empty))
    else $error("pixel write outside a visible span");

  // the walk address is always inside the frame
  a_pix_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_rd |-> (pbase < BW'(FRAME_DEPTH)))
    else $error("pixel address beyond frame depth");

  // divider finishes in the cycle after its last step
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    d_done |-> $past(d_busy && d_cnt == 5'd1))
    else $error("divider done without final step");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for shaded_triangle_span_fill_core: random and directed operations,
// with an in-bench predictor of the frame and shade stores. Depends on stsf_pkg.
`timescale 1ns / 100ps

module tb_top
  import stsf_pkg::*;
();

  localparam int ROW_PX    = 512;
  localparam int VIS_ROWS  = 200;
  localparam int FRM_OFS   = 96;
  localparam int N_TABLES  = 8;
  localparam int FRM_DEPTH = 131072;
  localparam int WDOG_MAX  = 1000000;
  // drawing window: all of row 1, and columns 0..WIN_COLS-1 of rows 2..WIN_ROWS
  localparam int WIN_ROWS  = 8;
  localparam int WIN_COLS  = 32;
  // apart from the directed extremes, frame and shade values stay in 0..VAL_MAX so every lookup hits a loaded entry
  localparam int VAL_MAX   = 7;

  typedef struct {
    stsf_mode_t               op;
    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
    logic [SEL_W-1:0]          sel;
    logic [ADDR_W-1:0]         addr;
    logic [BYTE_W-1:0]         wval;
  } op_item_t;

  typedef struct {
    logic [BYTE_W-1:0]  rd;
    logic [COUNT_W-1:0] cnt;
  } op_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic signed [COORD_W-1:0] vert_a_x = '0, vert_a_y = '0, vert_b_x = '0;
  logic signed [COORD_W-1:0] vert_b_y = '0, vert_c_x = '0, vert_c_y = '0;
  logic [SEL_W-1:0]   shade_select = '0;
  logic [ADDR_W-1:0]  address = '0;
  logic [BYTE_W-1:0]  write_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0]  read_value;
  logic [COUNT_W-1:0] pixels_shaded;

  shaded_triangle_span_fill_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .vert_a_x(vert_a_x), .vert_a_y(vert_a_y), .vert_b_x(vert_b_x),
    .vert_b_y(vert_b_y), .vert_c_x(vert_c_x), .vert_c_y(vert_c_y),
    .shade_select(shade_select), .address(address), .write_value(write_value),
    .out_valid(out_valid), .out_ready(out_ready), .read_value(read_value),
    .pixels_shaded(pixels_shaded)
  );

  op_item_t   pending_ops[$];
  op_result_t expected_results[$];
  logic [7:0] frame_mem [FRM_DEPTH];
  logic [7:0] shade_mem [N_TABLES*256];
  bit         written_map [FRM_DEPTH];
  int idle_pct = 0, stall_pct = 0;
  int fail_count = 0, draw_count = 0, read_count = 0;
  longint pixel_total = 0;
  logic in_taken = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic int unsigned shade_span(longint row, longint ea, longint eb, int tbl);
    longint lo, hi, l, r, a;
    int unsigned n;
    n = 0;
    lo = (ea < eb) ? ea : eb;
    hi = (ea < eb) ? eb : ea;
    if (row < 1 || row >= VIS_ROWS) return 0;
    l = (lo + longint'(LEFT_BIAS)) >>> 16;
    r = (hi + longint'(RIGHT_BIAS)) >>> 16;
    if (l < 0) l = 0;
    if (r > ROW_PX) r = ROW_PX;
    for (longint x = l; x < r; x++) begin
      a = (row * ROW_PX + x + FRM_OFS) % FRM_DEPTH;
      frame_mem[a] = shade_mem[tbl*256 + frame_mem[a]];
      n++;
    end
    return n;
  endfunction

  function automatic int unsigned fill_triangle(op_item_t it);
    longint vx[3], vy[3];
    longint x0, y0, x1, y1, x2, y2, row, lng, sht, s_long, s_short;
    int t, b, m, tbl;
    int unsigned n;
    n = 0;
    tbl = int'(it.sel) % N_TABLES;
    vx[0] = it.ax; vy[0] = it.ay;
    vx[1] = it.bx; vy[1] = it.by;
    vx[2] = it.cx; vy[2] = it.cy;
    // tie rules for top and bottom vertex choice
    if (vy[0] >= vy[1]) t = (vy[1] >= vy[2]) ? 2 : 1;
    else t = (vy[0] < vy[2]) ? 0 : 2;
    if (vy[0] <= vy[1]) b = (vy[1] <= vy[2]) ? 2 : 1;
    else b = (vy[0] > vy[2]) ? 0 : 2;
    if (vy[t] == vy[b]) return 0;
    m = 3 - t - b;
    x0 = vx[t]; y0 = vy[t]; x1 = vx[m]; y1 = vy[m]; x2 = vx[b]; y2 = vy[b];
    s_long = ((x2 - x0) * 65536) / (y2 - y0);
    lng = x0 * 65536;
    row = y0;
    if (y1 > y0) begin
      s_short = ((x1 - x0) * 65536) / (y1 - y0);
      sht = x0 * 65536;
      for (; row < y1; row++) begin
        n += shade_span(row, sht, lng, tbl);
        sht += s_short;
        lng += s_long;
      end
    end
    if (y2 > y1) begin
      s_short = ((x2 - x1) * 65536) / (y2 - y1);
      sht = x1 * 65536;
      for (; row < y2; row++) begin
        n += shade_span(row, sht, lng, tbl);
        sht += s_short;
        lng += s_long;
      end
    end
    return n;
  endfunction

  function automatic op_result_t apply_op(op_item_t it);
    op_result_t res;
    int unsigned n;
    res.rd = '0;
    res.cnt = '0;
    case (it.op)
      MODE_DRAW: begin
        n = fill_triangle(it);
        res.cnt = n[COUNT_W-1:0];
        draw_count++;
        pixel_total += n;
      end
      MODE_WRITE: frame_mem[it.addr] = it.wval;
      MODE_READ: begin
        res.rd = frame_mem[it.addr];
        read_count++;
      end
      default: shade_mem[(int'(it.sel) % N_TABLES)*256 + it.addr[7:0]] = it.wval;
    endcase
    return res;
  endfunction

  // ---------------- stimulus builders ----------------
  task automatic push_op(op_item_t it);
    if (it.op == MODE_WRITE) written_map[it.addr] = 1'b1;
    pending_ops.push_back(it);
  endtask

  task automatic push_draw(int ax, int ay, int bx, int by, int cx, int cy, int sel);
    op_item_t it;
    it.op = MODE_DRAW;
    it.ax = COORD_W'(ax); it.ay = COORD_W'(ay);
    it.bx = COORD_W'(bx); it.by = COORD_W'(by);
    it.cx = COORD_W'(cx); it.cy = COORD_W'(cy);
    it.sel = SEL_W'(sel);
    it.addr = ADDR_W'($urandom);
    it.wval = BYTE_W'($urandom);
    push_op(it);
  endtask

  task automatic push_access(stsf_mode_t op, int addr, int sel, int val);
    op_item_t it;
    it.op = op;
    {it.ax, it.ay, it.bx, it.by, it.cx, it.cy} = 72'({$urandom, $urandom, $urandom});
    it.sel = SEL_W'(sel);
    it.addr = ADDR_W'(addr);
    it.wval = BYTE_W'(val);
    push_op(it);
  endtask

  // frame address of a window pixel
  function automatic int win_addr(int r, int c);
    return r * ROW_PX + c + FRM_OFS;
  endfunction

  // read address that is known to hold data
  function automatic int pick_read_addr();
    int a;
    a = $urandom_range(FRM_DEPTH - 1);
    if (!written_map[a]) a = win_addr($urandom_range(WIN_ROWS, 1), $urandom_range(WIN_COLS - 1));
    return a;
  endfunction

  task automatic push_random_draw();
    int k, bx, by;
    k = $urandom_range(99);
    if (k < 3) begin
      // wide in x, narrow in y: row 1 only, or wholly outside the band
      case ($urandom_range(2))
        0: by = 1;
        1: by = -20;
        default: by = 205;
      endcase
      push_draw($urandom_range(4095) - 2048, by + $urandom_range(1),
                $urandom_range(4095) - 2048, by + $urandom_range(1),
                $urandom_range(4095) - 2048, by + $urandom_range(1),
                $urandom_range(7));
    end else if (k < 6) begin
      // tall in y, narrow in x, left of the frame
      bx = $urandom_range(2039) - 2048;
      push_draw(bx, $urandom_range(4095) - 2048, bx + $urandom_range(8),
                $urandom_range(4095) - 2048, bx - $urandom_range(8),
                $urandom_range(4095) - 2048, $urandom_range(7));
    end else begin
      // small triangle over the window
      push_draw($urandom_range(39) - 8, $urandom_range(13) - 4,
                $urandom_range(39) - 8, $urandom_range(13) - 4,
                $urandom_range(39) - 8, $urandom_range(13) - 4,
                $urandom_range(7));
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // ---------------- driver ----------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op_item_t it;
        it = pending_ops.pop_front();
        mode <= it.op;
        vert_a_x <= it.ax; vert_a_y <= it.ay;
        vert_b_x <= it.bx; vert_b_y <= it.by;
        vert_c_x <= it.cx; vert_c_y <= it.cy;
        shade_select <= it.sel;
        address <= it.addr;
        write_value <= it.wval;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor, checker and watchdog ----------------
  int quiet_cycles = 0;
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        op_item_t it;
        it.op = stsf_mode_t'(mode);
        it.ax = vert_a_x; it.ay = vert_a_y; it.bx = vert_b_x;
        it.by = vert_b_y; it.cx = vert_c_x; it.cy = vert_c_y;
        it.sel = shade_select;
        it.addr = address;
        it.wval = write_value;
        expected_results.push_back(apply_op(it));
      end
      if (out_valid && out_ready) begin
        op_result_t exp_r;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (read_value !== exp_r.rd) begin
            $error("read_value expected %0d got %0d", exp_r.rd, read_value);
            fail_count++;
          end
          if (pixels_shaded !== exp_r.cnt) begin
            $error("pixels_shaded expected %0d got %0d", exp_r.cnt, pixels_shaded);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles", WDOG_MAX);
        $display("shaded_triangle_span_fill_core verification failed");
        $finish;
      end
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // load the shade entries in use, then the drawing window of the frame
    for (int t = 0; t < N_TABLES; t++)
      for (int e = 0; e <= VAL_MAX; e++)
        push_access(MODE_LOAD, (($urandom_range(511)) << 8) | e, t, $urandom_range(VAL_MAX));
    for (int c = 0; c < ROW_PX; c++)
      push_access(MODE_WRITE, win_addr(1, c), $urandom_range(7), $urandom_range(VAL_MAX));
    for (int r = 2; r <= WIN_ROWS; r++)
      for (int c = 0; c < WIN_COLS; c++)
        push_access(MODE_WRITE, win_addr(r, c), $urandom_range(7), $urandom_range(VAL_MAX));
    wait_drained();

    // directed: field extremes, tie orderings and the special cases
    push_access(MODE_WRITE, FRM_DEPTH - 1, 7, 255);
    push_access(MODE_READ, FRM_DEPTH - 1, 0, 0);
    push_access(MODE_WRITE, 0, 0, 0);
    push_access(MODE_READ, 0, 7, 255);
    push_access(MODE_LOAD, 17'h1FFFF, 7, 255);
    push_draw(10, 5, 100, 5, 60, 5, 1);                // all on one row: nothing drawn
    push_draw(-2048, 2047, 2047, 2047, 0, 2047, 7);   // degenerate at the extremes
    push_draw(2, 2, 28, 2, 15, 9, 2);                  // flat top
    push_draw(15, 2, 2, 9, 28, 9, 3);                  // flat bottom
    push_draw(8, 3, 8, 3, 20, 9, 4);                   // a and b share the top row
    push_draw(8, 9, 20, 4, 26, 9, 5);                  // a and c share the bottom row
    push_draw(10, 1, 25, 5, 3, 9, 6);                  // middle vertex mid-way
    push_draw(-2048, -2048, 31, 2047, -2048, 2047, 0); // extremes, spans left of the frame
    push_draw(-40, 1, 560, 1, 250, 2, 1);              // clamped left and right on row 1
    push_draw(500, 200, 530, 205, 480, 215, 2);        // below the band: nothing touched
    push_draw(-100, -50, 31, -50, 31, 9, 3);           // tall triangle clipped to the window
    push_draw(2047, -2048, -2048, -2048, 20, 9, 4);
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 33 : 0;
      stall_pct = (ph == 2) ? 85 : (ph == 3) ? 33 : 0;
      for (int i = 0; i < 88; i++) begin
        case ($urandom_range(3))
          0: push_random_draw();
          1: push_access(MODE_WRITE, $urandom_range(FRM_DEPTH - 1), $urandom_range(7),
                         $urandom_range(VAL_MAX));
          2: push_access(MODE_READ, pick_read_addr(), $urandom_range(7), $urandom_range(255));
          default: push_access(MODE_LOAD, $urandom_range(FRM_DEPTH - 1), $urandom_range(7),
                               $urandom_range(VAL_MAX));
        endcase
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d draws shading %0d pixels and %0d frame reads,",
             draw_count, pixel_total, read_count);
    $display("over four handshake pressure phases after loading the window and shade entries");
    if (fail_count == 0) begin
      $display("shaded_triangle_span_fill_core verification clean");
    end else begin
      $display("shaded_triangle_span_fill_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/stsf_pkg.sv
hw/rtl/stsf_ram.sv
hw/rtl/stsf_ctrl.sv
hw/rtl/stsf_dp.sv
hw/rtl/shaded_triangle_span_fill_core.sv
bench/tb_top.sv
